[sv/decimal_seven_segment_driver_top_defines.svh]
// Assertion macros used by the top-level file to check this block.
`ifndef DECIMAL_SEVEN_SEGMENT_DRIVER_TOP_DEFINES_SVH
`define DECIMAL_SEVEN_SEGMENT_DRIVER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSSD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/dssd_pkg.sv]
`default_nettype none

package dssd_pkg;

  localparam int DIGIT_POSITIONS_DEF = 8;
  localparam int NUM_W = 16;
  localparam int DIGIT_W = 4;
  localparam int NUM_DIGITS = 5;
  localparam int BCD_W = NUM_DIGITS * DIGIT_W;
  localparam int BITS_PER_STEP = 2;
  localparam int CONV_STEPS = NUM_W / BITS_PER_STEP;
  localparam int Q_DEPTH = 2;
  localparam int Q_AW = 1;

  localparam logic OPC_NUMBER = 1'b0;
  localparam logic OPC_DIGIT = 1'b1;
  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [7:0] SEG_POINT_MASK = 8'h7F;
  localparam logic [7:0] SEG_BLANK = 8'hFF;

  typedef struct packed {
    logic        opcode;
    logic [15:0] number_value;
    logic [3:0]  digit_value;
    logic [2:0]  digit_position;
    logic        point_on;
  } in_t;

  typedef struct packed {
    logic [7:0] segment_code;
    logic [7:0] position_mask;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [2:0]       ndig;
    logic [2:0]       first_pos;
    logic             point;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'hC0;
      4'd1: s = 8'hF9;
      4'd2: s = 8'hA4;
      4'd3: s = 8'hB0;
      4'd4: s = 8'h99;
      4'd5: s = 8'h92;
      4'd6: s = 8'h82;
      4'd7: s = 8'hF8;
      4'd8: s = 8'h80;
      4'd9: s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[sv/dssd_front.sv]
`default_nettype none

module dssd_front import dssd_pkg::*; #(
  parameter int DIGIT_POSITIONS = DIGIT_POSITIONS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire in_t     in_data,
  input  wire q_stat_t q_stat,
  output logic         q_push,
  output entry_t       q_entry
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [NUM_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [2:0]       step_r, step_nxt;
  logic             accept;
  logic             digit_ok;
  logic [2:0]       ndig;

  function automatic logic [BCD_W+NUM_W-1:0] dd_step(input logic [BCD_W+NUM_W-1:0] v);
    logic [BCD_W+NUM_W-1:0] t;
    t = v;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (t[NUM_W + i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        t[NUM_W + i*DIGIT_W +: DIGIT_W] = t[NUM_W + i*DIGIT_W +: DIGIT_W] + 4'd3;
      end
    end
    return t << 1;
  endfunction

  assign in_stall = (state_r != ST_IDLE) | q_stat.full;
  assign accept = in_valid & ~in_stall;
  assign digit_ok = (in_data.digit_value <= DIGIT_MAX) &&
                    ({1'b0, in_data.digit_position} < 4'(DIGIT_POSITIONS));

  always_comb begin
    if (bcd_r[19:16] != 4'd0) begin
      ndig = 3'd5;
    end else if (bcd_r[15:12] != 4'd0) begin
      ndig = 3'd4;
    end else if (bcd_r[11:8] != 4'd0) begin
      ndig = 3'd3;
    end else if (bcd_r[7:4] != 4'd0) begin
      ndig = 3'd2;
    end else begin
      ndig = 3'd1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    step_nxt = step_r;
    q_push = 1'b0;
    q_entry.bcd = bcd_r;
    q_entry.ndig = ndig;
    q_entry.first_pos = 3'd0;
    q_entry.point = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.opcode == OPC_NUMBER) begin
            bin_nxt = in_data.number_value;
            bcd_nxt = '0;
            step_nxt = 3'd0;
            state_nxt = ST_CONV;
          end else if (digit_ok) begin
            q_push = 1'b1;
            q_entry.bcd = BCD_W'(in_data.digit_value);
            q_entry.ndig = 3'd1;
            q_entry.first_pos = in_data.digit_position;
            q_entry.point = in_data.point_on;
          end
        end
      end
      ST_CONV: begin
        {bcd_nxt, bin_nxt} = dd_step(dd_step({bcd_r, bin_r}));
        step_nxt = step_r + 3'd1;
        if (step_r == 3'(CONV_STEPS - 1)) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!q_stat.full) begin
          q_push = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r <= 3'd0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

endmodule

`default_nettype wire

[sv/dssd_queue.sv]
`default_nettype none

module dssd_queue import dssd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      head,
  output q_stat_t     stat
);

  entry_t          mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   count_r;

  assign stat.full = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/dssd_back.sv]
`default_nettype none

module dssd_back import dssd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire entry_t  head,
  input  wire q_stat_t q_stat,
  output logic         q_pop,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_t         out_data
);

  logic [2:0]       rem_r;
  logic [2:0]       pos_r;
  logic [BCD_W-1:0] sh_r;
  logic             point_r;
  logic             out_valid_r;
  out_t             out_r;
  logic [BCD_W-1:0] aligned;
  logic             emit;
  out_t             res;

  always_comb begin
    case (head.ndig)
      3'd1: aligned = head.bcd << (4 * DIGIT_W);
      3'd2: aligned = head.bcd << (3 * DIGIT_W);
      3'd3: aligned = head.bcd << (2 * DIGIT_W);
      3'd4: aligned = head.bcd << DIGIT_W;
      default: aligned = head.bcd;
    endcase
  end

  assign q_pop = (rem_r == 3'd0) & ~q_stat.empty;
  assign emit = (rem_r != 3'd0) & (~out_valid_r | ~out_stall);

  assign res.segment_code = seg_code(sh_r[BCD_W-1 -: DIGIT_W]) &
                            (point_r ? SEG_POINT_MASK : SEG_BLANK);
  assign res.position_mask = 8'd1 << pos_r;
  assign res.last_of_run = (rem_r == 3'd1);

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        rem_r <= head.ndig;
      end else if (emit) begin
        rem_r <= rem_r - 3'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sh_r <= aligned;
      pos_r <= head.first_pos;
      point_r <= head.point;
    end else if (emit) begin
      sh_r <= sh_r << DIGIT_W;
      pos_r <= pos_r + 3'd1;
    end
    if (emit) begin
      out_r <= res;
    end
  end

endmodule

`default_nettype wire

[sv/decimal_seven_segment_driver_top.sv]
// Seven-segment display driver. A show-number transaction converts its 16-bit
// value to decimal in the front end, two bits a cycle. Its digits are queued
// once converted and the queue is not full; the next transaction can be
// accepted in the cycle after that at the earliest. A show-digit transaction
// is queued in the cycle it is accepted, and one with a digit above nine or an
// unused position gives nothing. The back end takes a queued command and then
// sends one digit per cycle while the output is not stalled, most significant
// first at position 0 upward for a number and at its own position for a digit,
// with last_of_run marking each command's final digit. The front end stalls
// until a conversion has been queued and whenever the two-entry queue is full.
`default_nettype none

`include "decimal_seven_segment_driver_top_defines.svh"

module decimal_seven_segment_driver_top import dssd_pkg::*; #(
  parameter int DIGIT_POSITIONS = DIGIT_POSITIONS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  entry_t  q_entry;
  entry_t  q_head;

  dssd_front #(
    .DIGIT_POSITIONS(DIGIT_POSITIONS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  dssd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  dssd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `DSSD_ASSERT_SAME(a_no_overflow, q_push, !q_stat.full || q_pop, "queue written while full")
  `DSSD_ASSERT_SAME(a_bad_digit_dropped,
    in_valid && !in_stall && in_data.opcode == OPC_DIGIT && in_data.digit_value > DIGIT_MAX,
    !q_push, "illegal digit was queued")
  `DSSD_ASSERT_SAME(a_pop_not_empty, q_pop, !q_stat.empty, "queue read while empty")

endmodule

`default_nettype wire

[verif/tb_decimal_seven_segment_driver_top.sv]
`default_nettype none

module tb_decimal_seven_segment_driver_top;
  import dssd_pkg::*;

  localparam int RANDOM_COMMANDS = 350;
  localparam int CALM_FROM = 300;
  localparam int HOLD_AT = 120;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  class display_scoreboard;
    out_t digits_due[$];
    int   errors;

    function logic [7:0] glyph(input logic [3:0] d);
      case (d)
        4'd0: return 8'hC0;
        4'd1: return 8'hF9;
        4'd2: return 8'hA4;
        4'd3: return 8'hB0;
        4'd4: return 8'h99;
        4'd5: return 8'h92;
        4'd6: return 8'h82;
        4'd7: return 8'hF8;
        4'd8: return 8'h80;
        default: return 8'h90;
      endcase
    endfunction

    // Queues the digits a command should light and returns how many there are.
    function int note_command(input in_t cmd);
      logic [3:0] decimals[5];
      int         count;
      int unsigned rest;
      out_t       digit;
      count = 0;
      if (cmd.opcode == OPC_NUMBER) begin
        rest = 32'(cmd.number_value);
        do begin
          decimals[count] = 4'(rest % 10);
          rest = rest / 10;
          count++;
        end while (rest != 0 && count < NUM_DIGITS);
        for (int i = 0; i < count; i++) begin
          digit.segment_code = glyph(decimals[count - 1 - i]);
          digit.position_mask = 8'b1 << i;
          digit.last_of_run = (i == count - 1);
          digits_due.push_back(digit);
        end
      end else if (cmd.digit_value <= DIGIT_MAX &&
                   int'(cmd.digit_position) < DIGIT_POSITIONS_DEF) begin
        digit.segment_code = glyph(cmd.digit_value);
        if (cmd.point_on) begin
          digit.segment_code = digit.segment_code & SEG_POINT_MASK;
        end
        digit.position_mask = 8'b1 << cmd.digit_position;
        digit.last_of_run = 1'b1;
        digits_due.push_back(digit);
        count = 1;
      end
      return count;
    endfunction

    task report(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_digit(input out_t got);
      out_t want;
      if (digits_due.size() == 0) begin
        report($sformatf("unexpected result %h", got));
      end else begin
        want = digits_due.pop_front();
        if (got.segment_code !== want.segment_code) begin
          report($sformatf("segment_code %h, expected %h", got.segment_code,
                           want.segment_code));
        end
        if (got.position_mask !== want.position_mask) begin
          report($sformatf("position_mask %h, expected %h", got.position_mask,
                           want.position_mask));
        end
        if (got.last_of_run !== want.last_of_run) begin
          report($sformatf("last_of_run %b, expected %b", got.last_of_run,
                           want.last_of_run));
        end
      end
    endtask
  endclass

  display_scoreboard sb = new();

  int   lit_commands;
  bit   calm;
  logic long_hold;
  int   stall_left;
  int   cycle_count;

  decimal_seven_segment_driver_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("decimal_seven_segment_driver_top verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_digit(out_data);
    end
    if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 5);
    end
    out_stall <= long_hold || stall_left != 0;
    if (stall_left != 0) begin
      stall_left--;
    end
  end

  // The receiver holds off for a long stretch so that the block backs up.
  initial begin
    long_hold <= 1'b0;
    wait (lit_commands >= HOLD_AT);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  function automatic in_t make_number(input logic [15:0] value);
    in_t cmd;
    cmd = in_t'({$urandom, $urandom});
    cmd.opcode = OPC_NUMBER;
    cmd.number_value = value;
    return cmd;
  endfunction

  function automatic in_t make_digit(input logic [3:0] d, input logic [2:0] pos,
                                     input logic point);
    in_t cmd;
    cmd = in_t'({$urandom, $urandom});
    cmd.opcode = OPC_DIGIT;
    cmd.digit_value = d;
    cmd.digit_position = pos;
    cmd.point_on = point;
    return cmd;
  endfunction

  function automatic in_t random_command();
    int unsigned width;
    int unsigned low;
    int unsigned high;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      width = $urandom_range(1, NUM_DIGITS);
      low = (width == 1) ? 0 : 10 ** (width - 1);
      high = (width == NUM_DIGITS) ? 65535 : 10 ** width - 1;
      return make_number(16'($urandom_range(low, high)));
    end else if (pick < 95) begin
      return make_digit(4'($urandom_range(0, 9)), 3'($urandom), 1'($urandom));
    end
    return make_digit(4'($urandom_range(10, 15)), 3'($urandom), 1'($urandom));
  endfunction

  task automatic send_command(input in_t cmd);
    in_data <= cmd;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.note_command(cmd) != 0) begin
      lit_commands++;
    end
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  initial begin
    in_t cmd;
    int  random_lit;
    lit_commands = 0;
    calm = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_command(make_number(16'd0));
    send_command(make_number(16'd1));
    send_command(make_number(16'd9));
    send_command(make_number(16'd10));
    send_command(make_number(16'd99));
    send_command(make_number(16'd100));
    send_command(make_number(16'd1000));
    send_command(make_number(16'd9999));
    send_command(make_number(16'd10000));
    send_command(make_number(16'd12345));
    send_command(make_number(16'd65535));
    for (int d = 0; d <= 9; d++) begin
      send_command(make_digit(4'(d), 3'(d % 8), d[0]));
    end
    send_command(make_digit(4'd8, 3'd7, 1'b1));
    send_command(make_digit(4'd10, 3'd2, 1'b0));
    send_command(make_digit(4'd15, 3'd7, 1'b1));

    random_lit = 0;
    while (random_lit < RANDOM_COMMANDS) begin
      cmd = random_command();
      if (cmd.opcode == OPC_NUMBER || cmd.digit_value <= DIGIT_MAX) begin
        random_lit++;
      end
      calm = random_lit >= CALM_FROM;
      send_command(cmd);
    end
    in_valid <= 1'b0;

    while (sb.digits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("decimal_seven_segment_driver_top verification clean");
    end else begin
      $display("decimal_seven_segment_driver_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+sv
sv/dssd_pkg.sv
sv/dssd_front.sv
sv/dssd_queue.sv
sv/dssd_back.sv
sv/decimal_seven_segment_driver_top.sv
verif/tb_decimal_seven_segment_driver_top.sv
